// ----- sv/lkd_pkg.sv -----
package lkd_pkg;

	// display geometry
	localparam int DIGIT_COUNT = 8;
	localparam int MAX_PAIRS   = 8;
	localparam int PAIR_IDX_W  = $clog2(MAX_PAIRS);
	localparam int NPAIR_W     = $clog2(MAX_PAIRS + 1);

	// binary to BCD conversion, two bits per cycle
	localparam int MAG_W      = 28;
	localparam int BCD_DIGITS = 9;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int CONV_STEPS = MAG_W / 2;
	localparam int CNT_W      = $clog2(CONV_STEPS + 1);
	localparam int TEXT_MAX   = BCD_DIGITS + 1;
	localparam int TEXT_IDX_W = $clog2(TEXT_MAX);

	// byte sequencing
	localparam int INIT_LEN    = 19;
	localparam int KIDX_W      = $clog2(INIT_LEN);
	localparam int QUEUE_DEPTH = 2;

	// chip command bytes
	localparam logic [7:0] CMD_WRITE_AUTO  = 8'h40;
	localparam logic [7:0] CMD_WRITE_FIXED = 8'h44;
	localparam logic [7:0] CMD_ADDR        = 8'hC0;
	localparam logic [7:0] CMD_DISP_ON     = 8'h88;
	localparam logic [7:0] SEG_MINUS       = 8'h40;
	localparam logic [7:0] SEG_DOT         = 8'h80;
	localparam logic [3:0] BRIGHT_MAX      = 4'd7;

	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_BRIGHT = 3'd1,
		OP_LEDS   = 3'd2,
		OP_DIGIT  = 3'd3,
		OP_NUMBER = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		K_INIT   = 2'd0,
		K_BRIGHT = 2'd1,
		K_PAIRS  = 2'd2
	} kind_t;

	// one classified command: header, then address/data pairs
	typedef struct packed {
		kind_t                         kind;
		logic [7:0]                    first;
		logic [NPAIR_W-1:0]            npairs;
		logic [MAX_PAIRS-1:0][7:0]     addr;
		logic [MAX_PAIRS-1:0][7:0]     data;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_port_t;

	function automatic logic [7:0] seg_of(input logic [4:0] code);
		logic [7:0] s;
		unique case (code)
			5'd0:    s = 8'h3F;
			5'd1:    s = 8'h06;
			5'd2:    s = 8'h5B;
			5'd3:    s = 8'h4F;
			5'd4:    s = 8'h66;
			5'd5:    s = 8'h6D;
			5'd6:    s = 8'h7D;
			5'd7:    s = 8'h07;
			5'd8:    s = 8'h7F;
			5'd9:    s = 8'h6F;
			5'd10:   s = 8'h77;
			5'd11:   s = 8'h7C;
			5'd12:   s = 8'h39;
			5'd13:   s = 8'h5E;
			5'd14:   s = 8'h79;
			5'd15:   s = 8'h71;
			5'd17:   s = SEG_MINUS;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// ----- sv/lkd_front.sv -----
module lkd_front import lkd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic signed [27:0] number,
	input  logic [7:0]         led_mask,
	input  logic [3:0]         position,
	input  logic [4:0]         glyph,
	input  logic               dot,
	input  logic [3:0]         brightness,
	input  logic               q_full,
	output q_port_t            q_wr
);

	logic                  valid_s1;
	logic                  is_int_s1;
	logic                  drop_s1;
	logic                  neg_s1;
	logic [CNT_W-1:0]      cnt_s1;
	logic [MAG_W-1:0]      mag_s1;
	logic [BCD_W-1:0]      bcd_s1;
	cmd_t                  cmd_s1;

	cmd_t                  cmd_in;
	logic                  drop_in;
	logic                  is_int_in;
	logic [MAG_W-1:0]      raw_in;
	logic [MAG_W-1:0]      mag_in;
	logic                  accept;
	logic                  done;
	logic                  leave;

	logic [TEXT_IDX_W-1:0] nd;
	logic [TEXT_IDX_W-1:0] len;
	logic [TEXT_IDX_W-1:0] drop;
	logic [8*TEXT_MAX-1:0] text_v;
	logic [8*TEXT_MAX-1:0] text_sh;
	cmd_t                  cmd_int;

	// shift-add-3 step of binary to BCD
	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
			input logic bit_in);
		logic [BCD_W-1:0] t;
		t = b;
		for (int j = 0; j < BCD_DIGITS; j++) begin
			if (t[4*j +: 4] >= 4'd5) t[4*j +: 4] = t[4*j +: 4] + 4'd3;
		end
		return {t[BCD_W-2:0], bit_in};
	endfunction

	assign raw_in = MAG_W'(number);
	assign mag_in = raw_in[MAG_W-1] ? (~raw_in + MAG_W'(1)) : raw_in;

	always_comb begin
		cmd_in    = '0;
		drop_in   = 1'b0;
		is_int_in = 1'b0;
		unique case (op_t'(op))
			OP_INIT: cmd_in.kind = K_INIT;
			OP_BRIGHT: begin
				cmd_in.kind  = K_BRIGHT;
				cmd_in.first = CMD_DISP_ON | {4'b0, brightness};
				drop_in      = (brightness > BRIGHT_MAX);
			end
			OP_LEDS: begin
				cmd_in.kind   = K_PAIRS;
				cmd_in.npairs = NPAIR_W'(MAX_PAIRS);
				for (int i = 0; i < MAX_PAIRS; i++) begin
					cmd_in.addr[i] = CMD_ADDR | 8'(2 * i + 1);
					cmd_in.data[i] = {7'b0, led_mask[i]};
				end
			end
			OP_DIGIT: begin
				cmd_in.kind    = K_PAIRS;
				cmd_in.npairs  = NPAIR_W'(1);
				cmd_in.addr[0] = CMD_ADDR | {3'b0, position - 4'd1, 1'b0};
				cmd_in.data[0] = seg_of(glyph) | (dot ? SEG_DOT : 8'h00);
				drop_in = (position == 4'd0) || (position > 4'(DIGIT_COUNT));
			end
			OP_NUMBER: begin
				cmd_in.kind   = K_PAIRS;
				cmd_in.npairs = NPAIR_W'(DIGIT_COUNT);
				is_int_in     = 1'b1;
				for (int i = 0; i < DIGIT_COUNT; i++) begin
					cmd_in.addr[i] = CMD_ADDR | 8'((DIGIT_COUNT - 1 - i) * 2);
				end
			end
			default: drop_in = 1'b1;
		endcase
	end

	assign done     = (cnt_s1 == '0);
	assign leave    = valid_s1 && done && (drop_s1 || !q_full);
	assign in_stall = valid_s1 && !leave;
	assign accept   = in_valid && !in_stall;

	// decimal text: digits right-aligned, minus above the top digit,
	// low digits dropped when the text is wider than the display
	always_comb begin
		nd = TEXT_IDX_W'(1);
		for (int j = 1; j < BCD_DIGITS; j++) begin
			if (bcd_s1[4*j +: 4] != 4'd0) nd = TEXT_IDX_W'(j + 1);
		end
		len  = nd + TEXT_IDX_W'(neg_s1);
		drop = (len > TEXT_IDX_W'(DIGIT_COUNT)) ? len - TEXT_IDX_W'(DIGIT_COUNT) : '0;
		text_v = '0;
		for (int j = 0; j < BCD_DIGITS; j++) begin
			if (TEXT_IDX_W'(j) < nd) text_v[8*j +: 8] = seg_of({1'b0, bcd_s1[4*j +: 4]});
		end
		if (neg_s1) text_v[{nd, 3'b000} +: 8] = SEG_MINUS;
		text_sh = text_v >> {drop, 3'b000};
		cmd_int = cmd_s1;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			cmd_int.data[i] = text_sh[8*i +: 8];
		end
	end

	assign q_wr.valid = valid_s1 && done && !drop_s1 && !q_full;
	assign q_wr.cmd   = is_int_s1 ? cmd_int : cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s1   <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				cnt_s1   <= is_int_in ? CNT_W'(CONV_STEPS) : '0;
			end else begin
				if (leave) valid_s1 <= 1'b0;
				if (!done) cnt_s1 <= cnt_s1 - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd_in;
			drop_s1   <= drop_in;
			is_int_s1 <= is_int_in;
			neg_s1    <= raw_in[MAG_W-1];
			mag_s1    <= mag_in;
			bcd_s1    <= '0;
		end else if (!done) begin
			bcd_s1 <= dabble(dabble(bcd_s1, mag_s1[MAG_W-1]), mag_s1[MAG_W-2]);
			mag_s1 <= {mag_s1[MAG_W-3:0], 2'b00};
		end
	end

endmodule

// ----- sv/lkd_queue.sv -----
module lkd_queue import lkd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_port_t wr,
	output logic    full,
	input  logic    pop,
	output q_port_t rd
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.valid) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (wr.valid && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !wr.valid) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.valid) slot_q[wr_ptr_q] <= wr.cmd;
	end

endmodule

// ----- sv/lkd_back.sv -----
module lkd_back import lkd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_port_t    rd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] bus_byte,
	output logic       frame_start,
	output logic       frame_end,
	output logic       last
);

	logic              active_q;
	cmd_t              cur_q;
	logic [KIDX_W-1:0] k_q;
	logic              out_valid_q;
	logic [7:0]        bus_byte_q;
	logic              frame_start_q;
	logic              frame_end_q;
	logic              last_q;

	logic [KIDX_W-1:0]     km1;
	logic [PAIR_IDX_W-1:0] p;
	logic [7:0]            g_byte;
	logic                  g_start;
	logic                  g_end;
	logic                  g_last;
	logic                  adv;
	logic                  emit;

	assign km1 = k_q - KIDX_W'(1);
	assign p   = km1[PAIR_IDX_W:1];

	always_comb begin
		g_byte  = 8'h00;
		g_start = 1'b0;
		g_end   = 1'b0;
		g_last  = 1'b0;
		unique case (cur_q.kind)
			K_INIT: begin
				if (k_q == KIDX_W'(0)) begin
					g_byte  = CMD_WRITE_AUTO;
					g_start = 1'b1;
					g_end   = 1'b1;
				end else if (k_q == KIDX_W'(1)) begin
					g_byte  = CMD_ADDR;
					g_start = 1'b1;
				end else if (k_q == KIDX_W'(INIT_LEN - 1)) begin
					g_byte  = CMD_DISP_ON;
					g_start = 1'b1;
					g_end   = 1'b1;
					g_last  = 1'b1;
				end else begin
					g_end = (k_q == KIDX_W'(INIT_LEN - 2));
				end
			end
			K_BRIGHT: begin
				g_byte  = cur_q.first;
				g_start = 1'b1;
				g_end   = 1'b1;
				g_last  = 1'b1;
			end
			K_PAIRS: begin
				if (k_q == KIDX_W'(0)) begin
					g_byte  = CMD_WRITE_FIXED;
					g_start = 1'b1;
					g_end   = 1'b1;
				end else if (k_q[0]) begin
					g_byte  = cur_q.addr[p];
					g_start = 1'b1;
				end else begin
					g_byte = cur_q.data[p];
					g_end  = 1'b1;
					g_last = (k_q == KIDX_W'({cur_q.npairs, 1'b0}));
				end
			end
			default: ;
		endcase
	end

	assign adv  = !out_valid_q || !out_stall;
	assign emit = active_q && adv;
	assign pop  = rd.valid && (!active_q || (emit && g_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (adv) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				active_q <= 1'b1;
				k_q      <= '0;
			end else if (emit) begin
				k_q <= k_q + KIDX_W'(1);
				if (g_last) active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= rd.cmd;
		if (emit) begin
			bus_byte_q    <= g_byte;
			frame_start_q <= g_start;
			frame_end_q   <= g_end;
			last_q        <= g_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign bus_byte    = bus_byte_q;
	assign frame_start = frame_start_q;
	assign frame_end   = frame_end_q;
	assign last        = last_q;

endmodule

// ----- sv/led_key_display_command_encoder_top.sv -----
// Integers (op 4) run through two-bit-per-cycle binary to BCD conversion in the front stage.
// Throughput: one bus byte per cycle while out_stall is low; a command's byte count is
// 19 init, 17 led mask or integer, 3 digit, 1 brightness; an integer holds the input while it converts.
// Reset: arst_n low clears all control state asynchronously; queue and output empty.
module led_key_display_command_encoder_top import lkd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic signed [27:0] number,
	input  logic [7:0]         led_mask,
	input  logic [3:0]         position,
	input  logic [4:0]         glyph,
	input  logic               dot,
	input  logic [3:0]         brightness,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         bus_byte,
	output logic               frame_start,
	output logic               frame_end,
	output logic               last
);

	// front -> queue -> back
	q_port_t q_wr;
	q_port_t q_rd;
	logic    q_full;
	logic    q_pop;

	// tracks whether the strobe is currently low (a frame is open)
	logic    frame_open_q;

	// Front: takes an item, drops commands that emit nothing (bad op,
	// brightness above 7, position off the display), builds the header and
	// address/data pairs. Integers run through the BCD converter first.
	lkd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.number     (number),
		.led_mask   (led_mask),
		.position   (position),
		.glyph      (glyph),
		.dot        (dot),
		.brightness (brightness),
		.q_full     (q_full),
		.q_wr       (q_wr)
	);

	// Two-entry command queue: lets the front convert the next integer
	// while the back is still shifting out the previous command.
	lkd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.rd     (q_rd)
	);

	// Back: byte sequencer with registered output; loads the next command
	// on the cycle the last byte of the current one is registered into the output.
	lkd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd          (q_rd),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.bus_byte    (bus_byte),
		.frame_start (frame_start),
		.frame_end   (frame_end),
		.last        (last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			frame_open_q <= !frame_end;
		end
	end

	// strobe framing: a frame opens exactly when none is open
	a_frame_nesting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_start == !frame_open_q))
		else $error("frame_start does not match strobe state");

	// a command always ends with the strobe raised
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> frame_end)
		else $error("last byte leaves a frame open");

	// after a command's last byte is taken, the strobe is high
	a_idle_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> !frame_open_q)
		else $error("frame open after command end");

endmodule
